### hdl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### hdl/pfst_pkg.sv
// constants and helpers of the sieve-table prime factorizer
package pfst_pkg;

  localparam int TABLE_SIZE = 131072;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int NUM_W      = 17;
  localparam int EXP_W      = 5;
  localparam int DSEEN_W    = 3;
  localparam int MAX_RES    = 6;

  // integer square root, evaluated at elaboration only
  function automatic int isqrt(input int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  localparam int SIEVE_LIM = isqrt(TABLE_SIZE - 1);
  localparam int SIEVE_W   = $clog2(SIEVE_LIM + 2);

endpackage

### hdl/pfst_ram.sv
// generic single-port-write, single-port-read ram with registered read
module pfst_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/prime_factorizer_sieve_table_unit.sv
// top level of the sieve-table prime factorizer
//
// A number is transferred in at a rising edge with start high and busy low.
// Each result (prime, exponent, last_factor) is shown for exactly one cycle
// with strobe high; the receiver cannot hold results off. One result comes
// per distinct prime, largest sieve prime first, and last_factor marks the
// final one. 0, 1 and numbers beyond the table give one result with prime 0.
//
// After reset busy stays high while the factor store is built: an init pass
// writes each odd index from 3 up with itself and all others with zero,
// then the sieve writes every multiple of each prime up to the square root
// of the table, one write a cycle.
//
// Numbers 0 and 1 (and too large ones) give their result in the next cycle
// and leave busy low. Otherwise each prime factor, counted with multiplicity,
// passes through a store read, a wait for the read data, a 2-bit-per-cycle
// divider and an update, with busy high; a result is strobed as each run
// of equal primes ends.
`include "assert_macros.svh"

module prime_factorizer_sieve_table_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pfst_pkg::NUM_W-1:0] number,
  output logic                       busy,
  output logic                       strobe,
  output logic [pfst_pkg::NUM_W-1:0] prime,
  output logic [pfst_pkg::EXP_W-1:0] exponent,
  output logic                       last_factor
);

  import pfst_pkg::*;

  localparam int DIV_W     = NUM_W + 1;
  localparam int DIV_ITERS = DIV_W / 2;
  localparam int DCNT_W    = $clog2(DIV_ITERS);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_SIEVE_RD,
    S_SIEVE_CHK,
    S_SIEVE_WR,
    S_IDLE,
    S_LOOK,
    S_LWAIT,
    S_DIV,
    S_UPD
  } state_t;

  state_t state;

  // store fill
  logic [ADDR_W-1:0]  clr_addr;
  logic [SIEVE_W-1:0] sv_i;
  logic [ADDR_W:0]    sv_j;
  logic [ADDR_W:0]    sv_j_next;

  // factoring
  logic [NUM_W-1:0]   rem;
  logic [NUM_W-1:0]   run_prime;
  logic [EXP_W-1:0]   run_count;
  logic [DSEEN_W-1:0] distinct;
  logic [NUM_W-1:0]   cand;
  logic [NUM_W-1:0]   cand_sel;

  // divider
  logic [NUM_W-1:0]  div_d;
  logic [NUM_W-1:0]  div_r;
  logic [DIV_W-1:0]  div_q;
  logic [DCNT_W-1:0] div_cnt;
  logic [DIV_W-1:0]  t1, t2;
  logic              ge1, ge2;
  logic [NUM_W-1:0]  r1, r2;
  logic [DIV_W-1:0]  q1, q2;

  logic [NUM_W-1:0] p_eff;
  logic [NUM_W-1:0] q_eff;
  logic             num_trivial;

  // store port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [NUM_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [NUM_W-1:0]  ram_rdata;

  pfst_ram #(
    .WIDTH(NUM_W),
    .DEPTH(TABLE_SIZE)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy        = (state != S_IDLE);
  assign sv_j_next   = sv_j + (ADDR_W + 1)'(sv_i);
  assign num_trivial = (number < NUM_W'(2)) || (32'(number) >= 32'(TABLE_SIZE));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(sv_i);
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        // odd entries from 3 up start as their own index
        if (clr_addr[0] && (clr_addr != ADDR_W'(1))) begin
          ram_wdata = NUM_W'(clr_addr);
        end
      end
      S_SIEVE_RD: begin
        ram_re = 1'b1;
      end
      S_SIEVE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sv_j[ADDR_W-1:0];
        ram_wdata = NUM_W'(sv_i);
      end
      S_LOOK: begin
        ram_re    = (rem > NUM_W'(1));
        ram_raddr = ADDR_W'(rem);
      end
      default: begin
      end
    endcase
  end

  // unusable entry falls back to the remaining value
  assign cand     = ram_rdata;
  assign cand_sel = ((cand < NUM_W'(2)) || (cand > rem)) ? rem : cand;

  // two restoring steps per cycle
  always_comb begin
    t1  = {div_r, div_q[DIV_W-1]};
    ge1 = (t1 >= {1'b0, div_d});
    r1  = ge1 ? NUM_W'(t1 - {1'b0, div_d}) : t1[NUM_W-1:0];
    q1  = {div_q[DIV_W-2:0], ge1};
    t2  = {r1, q1[DIV_W-1]};
    ge2 = (t2 >= {1'b0, div_d});
    r2  = ge2 ? NUM_W'(t2 - {1'b0, div_d}) : t2[NUM_W-1:0];
    q2  = {q1[DIV_W-2:0], ge2};
  end

  // a nonzero remainder means the entry did not divide
  assign p_eff = (div_r != '0) ? rem : div_d;
  assign q_eff = (div_r != '0) ? NUM_W'(1) : div_q[NUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      sv_i     <= SIEVE_W'(2);
      distinct <= '0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(TABLE_SIZE - 1)) begin
            state <= S_SIEVE_RD;
          end
        end
        S_SIEVE_RD: begin
          state <= S_SIEVE_CHK;
        end
        S_SIEVE_CHK: begin
          // unmarked even entry or odd entry still holding itself is a prime
          if ((ram_rdata == '0) || (ram_rdata == NUM_W'(sv_i))) begin
            sv_j  <= (ADDR_W + 1)'(sv_i);
            state <= S_SIEVE_WR;
          end else if (sv_i == SIEVE_W'(SIEVE_LIM)) begin
            state <= S_IDLE;
          end else begin
            sv_i  <= sv_i + SIEVE_W'(1);
            state <= S_SIEVE_RD;
          end
        end
        S_SIEVE_WR: begin
          sv_j <= sv_j_next;
          if (sv_j_next > (ADDR_W + 1)'(TABLE_SIZE - 1)) begin
            if (sv_i == SIEVE_W'(SIEVE_LIM)) begin
              state <= S_IDLE;
            end else begin
              sv_i  <= sv_i + SIEVE_W'(1);
              state <= S_SIEVE_RD;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            distinct <= '0;
            if (num_trivial) begin
              strobe      <= 1'b1;
              prime       <= '0;
              exponent    <= '0;
              last_factor <= 1'b1;
            end else begin
              rem   <= number;
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (rem > NUM_W'(1)) begin
            state <= S_LWAIT;
          end else begin
            strobe      <= 1'b1;
            prime       <= run_prime;
            exponent    <= run_count;
            last_factor <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_LWAIT: begin
          div_d   <= cand_sel;
          div_r   <= '0;
          div_q   <= DIV_W'(rem);
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_r   <= r2;
          div_q   <= q2;
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_cnt == DCNT_W'(DIV_ITERS - 1)) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          priority if ((distinct != '0) && (p_eff == run_prime)) begin
            run_count <= run_count + EXP_W'(1);
            rem       <= q_eff;
            state     <= S_LOOK;
          end else if (distinct >= DSEEN_W'(MAX_RES)) begin
            strobe      <= 1'b1;
            prime       <= run_prime;
            exponent    <= run_count;
            last_factor <= 1'b1;
            state       <= S_IDLE;
          end else begin
            if (distinct != '0) begin
              strobe      <= 1'b1;
              prime       <= run_prime;
              exponent    <= run_count;
              last_factor <= 1'b0;
            end
            run_prime <= p_eff;
            run_count <= EXP_W'(1);
            distinct  <= distinct + DSEEN_W'(1);
            rem       <= q_eff;
            state     <= S_LOOK;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  `ASSERT_SAME(a_mid_result_busy, strobe && !last_factor, busy, "non-final result while idle")
  `ASSERT_NEXT(a_trivial_result, start && !busy && (number < 2), strobe && last_factor && (prime == 0), "0 or 1 did not give the empty result")
  `ASSERT_SAME(a_exp_nonzero, strobe && (prime != 0), exponent != 0, "prime result with zero exponent")
  `ASSERT_ALWAYS(a_distinct_max, distinct <= DSEEN_W'(MAX_RES), "too many distinct primes")
  `ASSERT_SAME(a_div_rem_bound, state == S_DIV, div_r < div_d, "partial remainder not below divisor")

endmodule

### bench/tb_top.sv
// testbench for the sieve-table prime factorizer: scoreboard class, stimulus and checks
`timescale 1ns / 100ps

module tb_top;
  import pfst_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0] prime;
    logic [EXP_W-1:0] exponent;
    logic             last_factor;
  } factor_result_t;

  class factor_scoreboard;
    logic [NUM_W-1:0] sieve_prime [TABLE_SIZE];
    factor_result_t   expected_factors [$];
    int               mismatches;

    // same contents as the block's store: later sieve primes overwrite earlier ones
    function new();
      int i;
      int j;
      mismatches = 0;
      for (i = 0; i < TABLE_SIZE; i++) sieve_prime[i] = '0;
      for (i = 2; i <= SIEVE_LIM; i++) begin
        if (sieve_prime[i] == '0) begin
          for (j = i; j < TABLE_SIZE; j += i) sieve_prime[j] = NUM_W'(i);
        end
      end
      for (i = 3; i < TABLE_SIZE; i += 2) begin
        if (sieve_prime[i] == '0) sieve_prime[i] = NUM_W'(i);
      end
    endfunction

    function void report_mismatch(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      mismatches++;
    endfunction

    function void add_expected(factor_result_t item);
      expected_factors = {expected_factors, item};
    endfunction

    // accepted number: queue one result per run of equal primes
    function void note_number(logic [NUM_W-1:0] value);
      int unsigned rest;
      int unsigned p;
      int unsigned run_p;
      int unsigned run_e;
      if (value < 2 || value >= TABLE_SIZE) begin
        add_expected(factor_result_t'{'0, '0, 1'b1});
        return;
      end
      rest  = 32'(value);
      run_p = 0;
      run_e = 0;
      // at 17 bits no number has more than six distinct primes
      while (rest > 1) begin
        p = 32'(sieve_prime[rest]);
        if (p < 2 || p > rest || (rest % p) != 0) p = rest;
        if (run_e != 0 && p == run_p) begin
          run_e++;
        end else begin
          if (run_e != 0) begin
            add_expected(
              factor_result_t'{run_p[NUM_W-1:0], run_e[EXP_W-1:0], 1'b0});
          end
          run_p = p;
          run_e = 1;
        end
        rest = rest / p;
      end
      add_expected(factor_result_t'{run_p[NUM_W-1:0], run_e[EXP_W-1:0], 1'b1});
    endfunction

    function void check_factor(logic [NUM_W-1:0] p, logic [EXP_W-1:0] e, logic l);
      factor_result_t want;
      if (expected_factors.size() == 0) begin
        report_mismatch($sformatf("prime %0d exponent %0d with nothing expected", p, e));
        return;
      end
      want = expected_factors.pop_front();
      if (p !== want.prime)
        report_mismatch($sformatf("prime %0d, expected %0d", p, want.prime));
      if (e !== want.exponent)
        report_mismatch($sformatf("exponent %0d for prime %0d, expected %0d",
                                  e, want.prime, want.exponent));
      if (l !== want.last_factor)
        report_mismatch($sformatf("last_factor %0b for prime %0d, expected %0b",
                                  l, want.prime, want.last_factor));
    endfunction

    function int pending();
      return expected_factors.size();
    endfunction
  endclass

  logic             clk;
  logic             rst    = 1'b1;
  logic             start  = 1'b0;
  logic [NUM_W-1:0] number = '0;
  logic             busy;
  logic             strobe;
  logic [NUM_W-1:0] prime;
  logic [EXP_W-1:0] exponent;
  logic             last_factor;

  factor_scoreboard sb;
  logic [NUM_W-1:0] corner_numbers [0:19];

  prime_factorizer_sieve_table_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .number      (number),
    .busy        (busy),
    .strobe      (strobe),
    .prime       (prime),
    .exponent    (exponent),
    .last_factor (last_factor)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (start === 1'b1 && busy === 1'b0) sb.note_number(number);
      if (strobe === 1'b1) sb.check_factor(prime, exponent, last_factor);
    end
  end

  // mostly back to back or short, now and then a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 40);
    return $urandom_range(100, 300);
  endfunction

  function automatic logic [NUM_W-1:0] pick_number();
    int unsigned v;
    int unsigned f;
    int          kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) return NUM_W'($urandom_range(0, 1));
    if (kind <= 3) return NUM_W'($urandom_range(0, 2**NUM_W - 1));
    if (kind == 4) return NUM_W'($urandom_range(2, 1000));
    if (kind == 9) return NUM_W'($urandom_range(2**(NUM_W-1), 2**NUM_W - 1));
    // smooth numbers: long runs and many distinct primes
    v = 1;
    repeat ($urandom_range(1, 18)) begin
      f = $urandom_range(2, ($urandom_range(0, 3) == 0) ? 40 : 7);
      if (v * f < 2**NUM_W) v = v * f;
    end
    return v[NUM_W-1:0];
  endfunction

  task automatic send_number(input logic [NUM_W-1:0] value, input int gap);
    start  <= 1'b1;
    number <= value;
    do @(posedge clk); while (busy !== 1'b0);
    if (gap > 0) begin
      start  <= 1'b0;
      number <= NUM_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every expected result has come
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int n;
    bit burst;
    sb = new();
    corner_numbers = '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd12, 17'd131071, 17'd65536,
                       17'd98304, 17'd131070, 17'd30030, 17'd120120, 17'd59049,
                       17'd130321, 17'd128881, 17'd367, 17'd129551, 17'd131042,
                       17'd111111, 17'd1};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_numbers[k])
      send_number(corner_numbers[k], (k % 4 == 3) ? $urandom_range(1, 20) : 0);
    drain();

    burst = 1'b0;
    for (n = 0; n < 400; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == 200) drain();
      send_number(pick_number(), burst ? 0 : pick_gap());
    end
    drain();
    repeat (40) @(posedge clk);

    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // the timeout also has to cover the store fill
  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
